[src/svg_pkg.sv]
// shared types, widths and constants for the sphere vertex generator
// no dependencies
package svg_pkg;

  localparam int STEP_W   = 10;
  localparam int DEN_W    = STEP_W + 1;
  localparam int ANG_W    = 32;
  localparam int XY_W     = 34;
  localparam int Z_W      = 32;
  localparam int OUT_W    = 16;
  localparam int CFG_IDX_W = 8;

  localparam int DEF_ROTATION_STAGES = 16;
  localparam int DEF_OUT_FRAC_BITS   = 15;

  localparam int ATAN_LEN = 24;

  localparam logic [STEP_W-1:0] LAT_STEPS_RESET = STEP_W'(32);
  localparam logic [STEP_W-1:0] LON_STEPS_RESET = STEP_W'(32);

  // start vector, cordic gain in q4.30
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_STEPS = CFG_IDX_W'(0),
    REG_LON_STEPS = CFG_IDX_W'(1)
  } reg_idx_t;

  typedef logic signed [Z_W-1:0] atan_tbl_t [0:ATAN_LEN-1];

  // atan(2^-i) in 2^32-per-turn units
  localparam atan_tbl_t ATAN_TURNS = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

[src/svg_div_cell.sv]
// one restoring-division cell: one quotient bit per beat
// depends on svg_pkg
module svg_div_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [svg_pkg::DEN_W-1:0]  rem_in,
  input  logic [svg_pkg::DEN_W-1:0]  den_in,
  input  logic [svg_pkg::ANG_W-1:0]  low_in,
  input  logic [svg_pkg::ANG_W-1:0]  quo_in,
  output logic [svg_pkg::DEN_W-1:0]  rem_out,
  output logic [svg_pkg::DEN_W-1:0]  den_out,
  output logic [svg_pkg::ANG_W-1:0]  low_out,
  output logic [svg_pkg::ANG_W-1:0]  quo_out
);
  import svg_pkg::*;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, low_in[ANG_W-1]};
    ge       = trial >= {1'b0, den_in};
    diff     = trial - {1'b0, den_in};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      den_out <= den_in;
      low_out <= {low_in[ANG_W-2:0], 1'b0};
      quo_out <= {quo_in[ANG_W-2:0], ge};
    end
  end

endmodule

[src/svg_cordic_cell.sv]
// one cordic rotation cell, fixed shift and arctangent per position
// depends on svg_pkg
module svg_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [svg_pkg::XY_W-1:0]   x_in,
  input  logic signed [svg_pkg::XY_W-1:0]   y_in,
  input  logic signed [svg_pkg::Z_W-1:0]    z_in,
  input  logic [1:0]                        q_in,
  output logic signed [svg_pkg::XY_W-1:0]   x_out,
  output logic signed [svg_pkg::XY_W-1:0]   y_out,
  output logic signed [svg_pkg::Z_W-1:0]    z_out,
  output logic [1:0]                        q_out
);
  import svg_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[Z_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN_TURNS[STAGE];
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN_TURNS[STAGE];
      end
      q_out <= q_in;
    end
  end

endmodule

[src/sphere_vertex_generator.sv]
// uv sphere vertex generator top level: angle dividers, cordic chains, products
// depends on svg_pkg, svg_div_cell, svg_cordic_cell
//
// Takes one grid point (lat_index, lon_index) per beat and returns the unit
// sphere point pos_x = sin(phi)cos(theta), pos_y = cos(phi),
// pos_z = sin(phi)sin(theta) with phi = pi*n/lat_steps and
// theta = 2*pi*m/lon_steps, in signed fixed point with OUT_FRAC_BITS fraction
// bits (q1.15 by default), rounded half up and saturated. Indexes above their
// resolution are clamped to it, a resolution of zero acts as one. The block is
// a fully pipelined row of cells and takes one beat per cycle; its stages are
// one input stage, 32 restoring-division cells per angle (one quotient bit
// each, both angles side by side), a quadrant stage, one cordic cell per
// rotation stage, a quadrant mapping stage, a multiply stage and the output
// register. The whole pipe advances together; it holds only while a result
// sits in the output register and out_stall is high, and in_stall shows
// exactly that. Configuration writes are always taken (cfg_ready is tied
// high); unknown indexes are ignored.
module sphere_vertex_generator #(
  parameter int ROTATION_STAGES = svg_pkg::DEF_ROTATION_STAGES,
  parameter int OUT_FRAC_BITS   = svg_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [svg_pkg::STEP_W-1:0]        cfg_data,
  // grid point beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [svg_pkg::STEP_W-1:0]        lat_index,
  input  logic [svg_pkg::STEP_W-1:0]        lon_index,
  // vertex beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [svg_pkg::OUT_W-1:0]  pos_x,
  output logic signed [svg_pkg::OUT_W-1:0]  pos_y,
  output logic signed [svg_pkg::OUT_W-1:0]  pos_z
);
  import svg_pkg::*;

  localparam int DIV_CELLS = ANG_W;
  localparam int LAT       = ROTATION_STAGES + DIV_CELLS + 5;
  localparam int PROD_W    = 2 * XY_W;
  localparam int SH_XZ     = 60 - OUT_FRAC_BITS;
  localparam int SH_Y      = 30 - OUT_FRAC_BITS;

  // configuration registers
  logic [STEP_W-1:0] lat_steps;
  logic [STEP_W-1:0] lon_steps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_steps <= LAT_STEPS_RESET;
      lon_steps <= LON_STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAT_STEPS: lat_steps <= cfg_data;
        REG_LON_STEPS: lon_steps <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe moves unless a finished vertex is held
  logic en;
  logic [LAT-1:0] vld;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // input stage: clamp, set up both divisions
  // phi = (n*2^31 + N/2) / N is done as (n*2^32 + 2*(N/2)) / (2N)
  logic [STEP_W-1:0] nres, mres, n_cl, m_cl;

  always_comb begin
    nres = (lat_steps == '0) ? STEP_W'(1) : lat_steps;
    mres = (lon_steps == '0) ? STEP_W'(1) : lon_steps;
    n_cl = (lat_index > nres) ? nres : lat_index;
    m_cl = (lon_index > mres) ? mres : lon_index;
  end

  logic [DEN_W-1:0] ph_rem [0:DIV_CELLS];
  logic [DEN_W-1:0] ph_den [0:DIV_CELLS];
  logic [ANG_W-1:0] ph_low [0:DIV_CELLS];
  logic [ANG_W-1:0] ph_quo [0:DIV_CELLS];
  logic [DEN_W-1:0] th_rem [0:DIV_CELLS];
  logic [DEN_W-1:0] th_den [0:DIV_CELLS];
  logic [ANG_W-1:0] th_low [0:DIV_CELLS];
  logic [ANG_W-1:0] th_quo [0:DIV_CELLS];

  always_ff @(posedge clk) begin
    if (en) begin
      ph_rem[0] <= {1'b0, n_cl};
      ph_den[0] <= {nres, 1'b0};
      ph_low[0] <= {{(ANG_W-STEP_W){1'b0}}, nres[STEP_W-1:1], 1'b0};
      ph_quo[0] <= '0;
      // full turn wraps to zero: drop the whole-turn quotient bit
      th_rem[0] <= (m_cl == mres) ? '0 : {1'b0, m_cl};
      th_den[0] <= {1'b0, mres};
      th_low[0] <= {{(ANG_W-STEP_W+1){1'b0}}, mres[STEP_W-1:1]};
      th_quo[0] <= '0;
    end
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    svg_div_cell u_ph (
      .clk(clk), .en(en),
      .rem_in(ph_rem[i]), .den_in(ph_den[i]), .low_in(ph_low[i]), .quo_in(ph_quo[i]),
      .rem_out(ph_rem[i+1]), .den_out(ph_den[i+1]), .low_out(ph_low[i+1]),
      .quo_out(ph_quo[i+1])
    );
    svg_div_cell u_th (
      .clk(clk), .en(en),
      .rem_in(th_rem[i]), .den_in(th_den[i]), .low_in(th_low[i]), .quo_in(th_quo[i]),
      .rem_out(th_rem[i+1]), .den_out(th_den[i+1]), .low_out(th_low[i+1]),
      .quo_out(th_quo[i+1])
    );
  end

  // quadrant stage: nearest quadrant, residual within +-45 degrees
  logic signed [XY_W-1:0] ph_x [0:ROTATION_STAGES];
  logic signed [XY_W-1:0] ph_y [0:ROTATION_STAGES];
  logic signed [Z_W-1:0]  ph_z [0:ROTATION_STAGES];
  logic [1:0]             ph_q [0:ROTATION_STAGES];
  logic signed [XY_W-1:0] th_x [0:ROTATION_STAGES];
  logic signed [XY_W-1:0] th_y [0:ROTATION_STAGES];
  logic signed [Z_W-1:0]  th_z [0:ROTATION_STAGES];
  logic [1:0]             th_q [0:ROTATION_STAGES];

  logic [ANG_W-1:0] phi, theta;
  assign phi   = ph_quo[DIV_CELLS];
  assign theta = th_quo[DIV_CELLS];

  always_ff @(posedge clk) begin
    if (en) begin
      ph_x[0] <= CORDIC_GAIN;
      ph_y[0] <= '0;
      ph_z[0] <= {{2{phi[29]}}, phi[29:0]};
      ph_q[0] <= phi[31:30] + {1'b0, phi[29]};
      th_x[0] <= CORDIC_GAIN;
      th_y[0] <= '0;
      th_z[0] <= {{2{theta[29]}}, theta[29:0]};
      th_q[0] <= theta[31:30] + {1'b0, theta[29]};
    end
  end

  for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
    svg_cordic_cell #(.STAGE(i)) u_ph (
      .clk(clk), .en(en),
      .x_in(ph_x[i]), .y_in(ph_y[i]), .z_in(ph_z[i]), .q_in(ph_q[i]),
      .x_out(ph_x[i+1]), .y_out(ph_y[i+1]), .z_out(ph_z[i+1]), .q_out(ph_q[i+1])
    );
    svg_cordic_cell #(.STAGE(i)) u_th (
      .clk(clk), .en(en),
      .x_in(th_x[i]), .y_in(th_y[i]), .z_in(th_z[i]), .q_in(th_q[i]),
      .x_out(th_x[i+1]), .y_out(th_y[i+1]), .z_out(th_z[i+1]), .q_out(th_q[i+1])
    );
  end

  // quadrant mapping to cos / sin, q4.30
  logic signed [XY_W-1:0] cp, sp, ct, st;
  logic signed [XY_W-1:0] rx_p, ry_p, rx_t, ry_t;

  assign rx_p = ph_x[ROTATION_STAGES];
  assign ry_p = ph_y[ROTATION_STAGES];
  assign rx_t = th_x[ROTATION_STAGES];
  assign ry_t = th_y[ROTATION_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      case (ph_q[ROTATION_STAGES])
        2'd0:    begin cp <= rx_p;  sp <= ry_p;  end
        2'd1:    begin cp <= -ry_p; sp <= rx_p;  end
        2'd2:    begin cp <= -rx_p; sp <= -ry_p; end
        default: begin cp <= ry_p;  sp <= -rx_p; end
      endcase
      case (th_q[ROTATION_STAGES])
        2'd0:    begin ct <= rx_t;  st <= ry_t;  end
        2'd1:    begin ct <= -ry_t; st <= rx_t;  end
        2'd2:    begin ct <= -rx_t; st <= -ry_t; end
        default: begin ct <= ry_t;  st <= -rx_t; end
      endcase
    end
  end

  // products, q8.60
  logic signed [PROD_W-1:0] prod_x, prod_z;
  logic signed [XY_W-1:0]   cp_d;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= sp * ct;
      prod_z <= sp * st;
      cp_d   <= cp;
    end
  end

  // round half up, then saturate
  localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] OUT_MIN = -PROD_W'(32768);

  logic signed [PROD_W-1:0] rx, rz, ry;

  always_comb begin
    rx = (prod_x + (PROD_W'(1) <<< (SH_XZ - 1))) >>> SH_XZ;
    rz = (prod_z + (PROD_W'(1) <<< (SH_XZ - 1))) >>> SH_XZ;
  end

  if (SH_Y == 0) begin : g_ry_exact
    assign ry = PROD_W'(cp_d);
  end else begin : g_ry_round
    assign ry = (PROD_W'(cp_d) + (PROD_W'(1) <<< (SH_Y - 1))) >>> SH_Y;
  end

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX)      r = 16'sh7fff;
    else if (v < OUT_MIN) r = 16'sh8000;
    else                  r = v[OUT_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x <= sat16(rx);
      pos_y <= sat16(ry);
      pos_z <= sat16(rz);
    end
  end

endmodule

[src/svg_checker.sv]
// port-level checks for the sphere vertex generator, bound to the top level
// depends on svg_pkg and sphere_vertex_generator
module svg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [svg_pkg::OUT_W-1:0]  pos_x,
  input logic signed [svg_pkg::OUT_W-1:0]  pos_y,
  input logic signed [svg_pkg::OUT_W-1:0]  pos_z
);

  // input is held back only by a held vertex
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held vertex");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // a held vertex keeps its valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("vertex dropped while stalled");

  // a held vertex keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(pos_x) && $stable(pos_y) && $stable(pos_z)))
    else $error("vertex changed while stalled");

endmodule

bind sphere_vertex_generator svg_checker u_svg_checker (.*);

[dv/sphere_vertex_generator_test.sv]
`timescale 1ns / 100ps
// self-checking bench for the uv sphere vertex generator: random and directed grid points
// depends on svg_pkg and the sphere_vertex_generator rtl
module sphere_vertex_generator_test;
  import svg_pkg::*;

  localparam int STAGES     = DEF_ROTATION_STAGES;
  localparam int FRAC       = DEF_OUT_FRAC_BITS;
  localparam int PIPE_DEPTH = DEF_ROTATION_STAGES + 37;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } vertex_t;

  // holds the expected vertices and the register copies they are computed from
  class vertex_scoreboard;
    vertex_t pending[$];
    int unsigned lat_res = 32'(LAT_STEPS_RESET);
    int unsigned lon_res = 32'(LON_STEPS_RESET);
    int mismatches = 0;
    int matched = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
      if (idx == REG_LAT_STEPS) lat_res = 32'(val);
      else if (idx == REG_LON_STEPS) lon_res = 32'(val);
    endfunction

    // cosine and sine of a 32-bit turn angle in q2.30
    function void turn_sincos(logic [31:0] ang, output longint c, output longint s);
      logic [1:0] quad;
      longint x, y, z, dx, dy;
      quad = ang[31:30];
      z = longint'({2'b00, ang[29:0]});
      x = longint'(CORDIC_GAIN);
      y = 0;
      if (z >= (longint'(1) <<< 29)) begin
        z -= longint'(1) <<< 30;
        quad = quad + 2'd1;
      end
      for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
        end
      end
      case (quad)
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic signed [OUT_W-1:0] round_sat(longint v, int sh);
      longint r;
      r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[OUT_W-1:0];
    endfunction

    // input beat accepted: work out the vertex it must produce
    function void note_point(logic [STEP_W-1:0] lat, logic [STEP_W-1:0] lon);
      longint unsigned nres, mres, n, m, t;
      logic [31:0] phi, theta;
      longint cp, sp, ct, st;
      vertex_t v;
      nres = (lat_res == 0) ? 1 : 64'(lat_res);
      mres = (lon_res == 0) ? 1 : 64'(lon_res);
      n = (64'(lat) > nres) ? nres : 64'(lat);
      m = (64'(lon) > mres) ? mres : 64'(lon);
      t = (n * 64'h8000_0000 + nres / 2) / nres;
      phi = t[31:0];
      t = ((m << 32) + mres / 2) / mres;
      theta = t[31:0];   // full turn wraps to zero
      turn_sincos(phi, cp, sp);
      turn_sincos(theta, ct, st);
      v.x = round_sat(sp * ct, 60 - FRAC);
      v.y = round_sat(cp, 30 - FRAC);
      v.z = round_sat(sp * st, 60 - FRAC);
      pending.insert(pending.size(), v);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_vertex(logic signed [OUT_W-1:0] x, y, z);
      vertex_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected vertex beat, pos_x", x, 0);
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) report_mismatch("pos_x", x, e.x);
      if (y !== e.y) report_mismatch("pos_y", y, e.y);
      if (z !== e.z) report_mismatch("pos_z", z, e.z);
      matched++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [STEP_W-1:0] lat_index = '0;
  logic [STEP_W-1:0] lon_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] pos_x, pos_y, pos_z;

  vertex_scoreboard sb = new();

  int unsigned cycles = 0;
  int unsigned points_sent = 0;
  int send_idle_pct = 14;     // sender idle chance per cycle
  int recv_idle_pct = 47;     // receiver stall chance per cycle
  bit hold_done = 1'b0;

  sphere_vertex_generator dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("sphere_vertex_generator verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off so the pipe fills and backs up
  always @(posedge clk) begin
    if (!rst && !hold_done && points_sent >= 150) begin
      hold_done = 1'b1;
      out_stall <= 1'b1;
      repeat (300) @(posedge clk);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // output monitor, sampled before the edge updates land
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_vertex(pos_x, pos_y, pos_z);
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one grid point beat; each cycle before it the sender may idle
  task send_point(logic [STEP_W-1:0] lat, logic [STEP_W-1:0] lon);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    lat_index <= lat;
    lon_index <= lon;
    do @(posedge clk); while (in_stall);
    sb.note_point(lat, lon);
    points_sent++;
  endtask

  // wait for every vertex, then let the pipe settle before touching registers
  task drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task random_points(int count);
    int unsigned lr, nr;
    for (int i = 0; i < count; i++) begin
      // idling profile moves with overall progress
      if (points_sent < 450) begin
        send_idle_pct = 14; recv_idle_pct = 47;
      end else if (points_sent < 900) begin
        send_idle_pct = 47; recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      lr = (sb.lat_res == 0) ? 1 : sb.lat_res;
      nr = (sb.lon_res == 0) ? 1 : sb.lon_res;
      if ($urandom_range(9) < 8)
        send_point(STEP_W'($urandom_range(lr)), STEP_W'($urandom_range(nr)));
      else  // clamp path
        send_point(STEP_W'($urandom_range(1023)), STEP_W'($urandom_range(1023)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed at reset resolution: poles, equator, quadrants, wrap, clamp
    send_point(0, 0);
    send_point(32, 0);
    send_point(16, 0);
    send_point(16, 8);
    send_point(16, 16);
    send_point(16, 24);
    send_point(16, 32);
    send_point(8, 4);
    send_point(1023, 1023);
    send_point(33, 40);
    send_point(24, 12);
    drain();

    // tiny and zero resolutions
    write_reg(REG_LAT_STEPS, 1);
    write_reg(REG_LON_STEPS, 1);
    send_point(0, 0);
    send_point(1, 1);
    send_point(1023, 512);
    drain();
    write_reg(REG_LAT_STEPS, 0);
    write_reg(REG_LON_STEPS, 0);
    write_reg(REG_UNUSED, 1023);   // ignored index
    send_point(0, 1);
    send_point(1, 0);
    send_point(1023, 1023);
    drain();

    // largest resolutions
    write_reg(REG_LAT_STEPS, 1023);
    write_reg(REG_LON_STEPS, 1023);
    send_point(511, 0);
    send_point(512, 256);
    send_point(1023, 1023);
    send_point(1, 1022);
    random_points(300);
    drain();

    write_reg(REG_LAT_STEPS, 32);
    write_reg(REG_LON_STEPS, 32);
    random_points(250);
    drain();

    write_reg(REG_LAT_STEPS, 3);
    write_reg(REG_LON_STEPS, 1000);
    random_points(200);
    drain();

    write_reg(REG_LAT_STEPS, 1023);
    write_reg(REG_LON_STEPS, 7);
    random_points(200);
    drain();

    write_reg(REG_LAT_STEPS, STEP_W'($urandom_range(1, 1023)));
    write_reg(REG_LON_STEPS, STEP_W'($urandom_range(1, 1023)));
    random_points(250);
    drain();

    $display("covered %0d grid points and %0d checked vertices over extreme and random",
             points_sent, sb.matched);
    $display("resolutions, with sender and receiver gaps and one long output hold-off");
    if (sb.mismatches == 0)
      $display("sphere_vertex_generator verification clean");
    else
      $display("sphere_vertex_generator verification failed");
    $finish;
  end
endmodule
